[sv/cbm_pkg.sv]
// Shared constants and types for the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

    localparam int unsigned KindWidth = 2;
    localparam int unsigned TargetWidth = 3;
    localparam int unsigned MappedWidth = 21;
    localparam int unsigned RomBankWidth = 7;
    localparam int unsigned RamBankWidth = 2;
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned ApbDataWidth = 32;

    typedef logic [KindWidth-1:0] kind_t;
    typedef logic [TargetWidth-1:0] target_t;

    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_MBC1 = 2'd1;
    localparam kind_t KIND_MBC2 = 2'd2;
    localparam kind_t KIND_MBC3 = 2'd3;

    localparam target_t TGT_BOOT = 3'd0;
    localparam target_t TGT_ROM = 3'd1;
    localparam target_t TGT_RAM = 3'd2;
    localparam target_t TGT_BANKREG = 3'd3;
    localparam target_t TGT_OTHER = 3'd4;

    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] CLOCK_SEL_LOW = 8'h08;
    localparam logic [7:0] CLOCK_SEL_HIGH = 8'h0C;

    typedef struct packed {
        target_t target;
        logic [MappedWidth-1:0] mapped_address;
        logic ram_write_ok;
    } result_t;

endpackage
`default_nettype wire

[sv/cartridge_bank_mapper_unit.sv]
// Top level of the cartridge bank mapper: bus access decode and banking registers.
`default_nettype none
// Maps one CPU bus access per cycle. Each accepted word is decoded against the
// current banking state in a single pass and its result lands in the output
// register on the next clock edge, so one word enters and one result leaves
// every cycle; the only limit is the output register, which stalls the input
// only while a result waits with m_ready low. Writes below 0x8000 update the
// banking state at the edge that accepts them, so the next word already sees
// the new bank. The controller kind (0 none, 1 MBC1, 2 MBC2, 3 MBC3) lives in
// APB address 0, set by the user only while the bus is idle; not enforced.
module cartridge_bank_mapper_unit
    import cbm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [ApbDataWidth-1:0] pwdata,
    output logic      [ApbDataWidth-1:0] prdata,
    output logic                         pready,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_mode,
    input  wire logic [15:0]             s_bus_address,
    input  wire logic [7:0]              s_write_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [TargetWidth-1:0]  m_target,
    output logic      [MappedWidth-1:0]  m_mapped_address,
    output logic                         m_ram_write_ok
);

    kind_t                   kind_reg;
    logic [RomBankWidth-1:0] rom_bank_reg, rom_bank_next;
    logic [RamBankWidth-1:0] ram_bank_reg, ram_bank_next;
    logic                    ram_enabled_reg, ram_enabled_next;
    logic                    banking_mode_reg, banking_mode_next;
    logic                    ram_select_reg, ram_select_next;
    logic                    boot_overlay_reg, boot_overlay_next;
    logic                    out_valid_reg;
    result_t                 result_reg, result_next;
    logic                    accept;
    logic                    cfg_write;
    logic                    in_ram;
    logic [4:0]              low_bank;
    logic [RomBankWidth-1:0] upper_bank;
    logic [MappedWidth-1:0]  rom_mapped;
    logic [MappedWidth-1:0]  ram_mapped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ApbAddrWidth-1] == 1'b0);
    assign prdata    = (paddr[ApbAddrWidth-1] == 1'b0)
                       ? {{(ApbDataWidth-KindWidth){1'b0}}, kind_reg} : '0;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign in_ram     = (s_bus_address[15:13] == 3'b101);
    assign rom_mapped = {rom_bank_reg, s_bus_address[13:0]};
    assign ram_mapped = {{(MappedWidth-RamBankWidth-13){1'b0}}, ram_bank_reg,
                         s_bus_address[12:0]};
    assign low_bank   = (s_write_data[4:0] == 5'd0) ? 5'd1 : s_write_data[4:0];
    assign upper_bank = {s_write_data[1:0], rom_bank_reg[4:0]};

    always_comb begin
        result_next.target         = TGT_OTHER;
        result_next.mapped_address = {{(MappedWidth-16){1'b0}}, s_bus_address};
        result_next.ram_write_ok   = 1'b0;
        rom_bank_next     = rom_bank_reg;
        ram_bank_next     = ram_bank_reg;
        ram_enabled_next  = ram_enabled_reg;
        banking_mode_next = banking_mode_reg;
        ram_select_next   = ram_select_reg;
        boot_overlay_next = boot_overlay_reg;
        if (s_mode) begin
            if (s_bus_address[15] == 1'b0) begin
                result_next.target = TGT_BANKREG;
                if (kind_reg != KIND_NONE) begin
                    case (s_bus_address[14:13])
                        2'b00: begin
                            if (!(kind_reg == KIND_MBC2 && s_bus_address[4])) begin
                                ram_enabled_next = (s_write_data[3:0] == RAM_ENABLE_KEY);
                            end
                        end
                        2'b01: begin
                            case (kind_reg)
                                KIND_MBC1: rom_bank_next = {rom_bank_reg[6:5], low_bank};
                                KIND_MBC2: rom_bank_next = (s_write_data[3:0] == 4'd0)
                                    ? 7'd1 : {3'd0, s_write_data[3:0]};
                                default: rom_bank_next = (s_write_data[6:0] == 7'd0)
                                    ? 7'd1 : s_write_data[6:0];
                            endcase
                        end
                        2'b10: begin
                            if (kind_reg == KIND_MBC1) begin
                                if (banking_mode_reg) begin
                                    ram_bank_next = s_write_data[1:0];
                                end else begin
                                    rom_bank_next = (upper_bank == 7'd0) ? 7'd1 : upper_bank;
                                end
                            end else if (kind_reg == KIND_MBC3) begin
                                if (s_write_data <= 8'd3) begin
                                    ram_select_next = 1'b1;
                                    ram_bank_next   = s_write_data[1:0];
                                end else if (s_write_data >= CLOCK_SEL_LOW
                                             && s_write_data <= CLOCK_SEL_HIGH) begin
                                    ram_select_next = 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (kind_reg == KIND_MBC1) begin
                                banking_mode_next = s_write_data[0];
                                if (!s_write_data[0]) begin
                                    ram_bank_next = '0;
                                end
                            end
                        end
                    endcase
                end
            end else if (in_ram) begin
                result_next.target         = TGT_RAM;
                result_next.mapped_address = ram_mapped;
                result_next.ram_write_ok   = ram_enabled_reg && ram_select_reg;
            end else if (s_bus_address == BOOT_OFF_ADDR) begin
                boot_overlay_next = (s_write_data != 8'd1);
            end
        end else begin
            if (s_bus_address[15:8] == 8'd0 && boot_overlay_reg) begin
                result_next.target = TGT_BOOT;
            end else if (s_bus_address[15:14] == 2'b00) begin
                result_next.target = TGT_ROM;
            end else if (s_bus_address[15:14] == 2'b01) begin
                result_next.target         = TGT_ROM;
                result_next.mapped_address = rom_mapped;
            end else if (in_ram) begin
                result_next.target         = TGT_RAM;
                result_next.mapped_address = ram_mapped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg         <= KIND_NONE;
            rom_bank_reg     <= 7'd1;
            ram_bank_reg     <= '0;
            ram_enabled_reg  <= 1'b0;
            banking_mode_reg <= 1'b1;
            ram_select_reg   <= 1'b1;
            boot_overlay_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                kind_reg <= pwdata[KindWidth-1:0];
            end
            if (accept) begin
                rom_bank_reg     <= rom_bank_next;
                ram_bank_reg     <= ram_bank_next;
                ram_enabled_reg  <= ram_enabled_next;
                banking_mode_reg <= banking_mode_next;
                ram_select_reg   <= ram_select_next;
                boot_overlay_reg <= boot_overlay_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_target         = result_reg.target;
    assign m_mapped_address = result_reg.mapped_address;
    assign m_ram_write_ok   = result_reg.ram_write_ok;

endmodule
`default_nettype wire

[dv/cartridge_bank_mapper_unit_test.sv]
// Self-checking testbench for the cartridge bank mapper: directed and random bus words.
module cartridge_bank_mapper_unit_test
    import cbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACC_READ = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic [ApbAddrWidth-1:0] KIND_REG_ADDR = '0;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned WORDS_PER_KIND = 90;

    logic aclk;
    logic aresetn;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [ApbDataWidth-1:0] pwdata;
    logic [ApbDataWidth-1:0] prdata;
    logic pready;
    logic s_valid;
    logic s_ready;
    logic s_mode;
    logic [15:0] s_bus_address;
    logic [7:0] s_write_data;
    logic m_valid;
    logic m_ready;
    logic [TargetWidth-1:0] m_target;
    logic [MappedWidth-1:0] m_mapped_address;
    logic m_ram_write_ok;

    cartridge_bank_mapper_unit DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_bus_address(s_bus_address),
        .s_write_data(s_write_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_target(m_target),
        .m_mapped_address(m_mapped_address),
        .m_ram_write_ok(m_ram_write_ok)
    );

    // Predicted banking state of the cartridge.
    kind_t ctrl_kind;
    logic [RomBankWidth-1:0] rom_bank_sel;
    logic [RamBankWidth-1:0] ram_bank_sel;
    logic cart_ram_open;
    logic mbc1_ram_mode;
    logic ram_over_clock;
    logic boot_rom_mapped;

    result_t expected_maps [$];
    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned target_hits [5];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned stall_cycles;
    int unsigned hold_left;
    bit hold_pending;

    kind_t kind_order [4] = '{KIND_MBC1, KIND_MBC3, KIND_NONE, KIND_MBC2};
    int unsigned send_mix [4] = '{0, 45, 0, 19};
    int unsigned recv_mix [4] = '{0, 0, 45, 19};

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    function automatic result_t map_bus_access(input logic is_write, input logic [15:0] addr,
                                               input logic [7:0] data);
        result_t res;
        logic [6:0] low_bits;
        res.target = TGT_OTHER;
        res.mapped_address = MappedWidth'(addr);
        res.ram_write_ok = 1'b0;
        if (is_write == ACC_WRITE) begin
            if (addr < 16'h8000) begin
                res.target = TGT_BANKREG;
                if (ctrl_kind != KIND_NONE) begin
                    case (addr[14:13])
                        2'b00: begin
                            if (!(ctrl_kind == KIND_MBC2 && addr[4]))
                                cart_ram_open = (data[3:0] == RAM_ENABLE_KEY);
                        end
                        2'b01: begin
                            if (ctrl_kind == KIND_MBC1) begin
                                low_bits = {2'b00, data[4:0]};
                                if (low_bits == 7'd0)
                                    low_bits = 7'd1;
                                rom_bank_sel = {rom_bank_sel[6:5], low_bits[4:0]};
                            end else begin
                                low_bits = (ctrl_kind == KIND_MBC2) ? {3'b000, data[3:0]}
                                                                    : data[6:0];
                                rom_bank_sel = (low_bits == 7'd0) ? 7'd1 : low_bits;
                            end
                        end
                        2'b10: begin
                            if (ctrl_kind == KIND_MBC1) begin
                                if (mbc1_ram_mode) begin
                                    ram_bank_sel = data[1:0];
                                end else begin
                                    rom_bank_sel = {data[1:0], rom_bank_sel[4:0]};
                                    if (rom_bank_sel == 7'd0)
                                        rom_bank_sel = 7'd1;
                                end
                            end else if (ctrl_kind == KIND_MBC3) begin
                                if (data <= 8'd3) begin
                                    ram_over_clock = 1'b1;
                                    ram_bank_sel = data[1:0];
                                end else if (data >= CLOCK_SEL_LOW && data <= CLOCK_SEL_HIGH) begin
                                    ram_over_clock = 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (ctrl_kind == KIND_MBC1) begin
                                mbc1_ram_mode = data[0];
                                if (!data[0])
                                    ram_bank_sel = '0;
                            end
                        end
                    endcase
                end
            end else if (addr[15:13] == 3'b101) begin
                res.target = TGT_RAM;
                res.mapped_address = {6'd0, ram_bank_sel, addr[12:0]};
                res.ram_write_ok = cart_ram_open && ram_over_clock;
            end else if (addr == BOOT_OFF_ADDR) begin
                boot_rom_mapped = (data != 8'd1);
            end
        end else begin
            if (addr < 16'h0100 && boot_rom_mapped) begin
                res.target = TGT_BOOT;
            end else if (addr < 16'h4000) begin
                res.target = TGT_ROM;
            end else if (addr < 16'h8000) begin
                res.target = TGT_ROM;
                res.mapped_address = {rom_bank_sel, addr[13:0]};
            end else if (addr[15:13] == 3'b101) begin
                res.target = TGT_RAM;
                res.mapped_address = {6'd0, ram_bank_sel, addr[12:0]};
            end
        end
        return res;
    endfunction

    task automatic send_word(input logic mode, input logic [15:0] addr, input logic [7:0] data);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_bus_address <= addr;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        expected_maps.push_back(map_bus_access(mode, addr, data));
        words_sent++;
    endtask

    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_maps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_maps.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", expected_maps.size()));
            expected_maps.delete();
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_kind(input kind_t kind);
        wait_for_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= KIND_REG_ADDR;
        pwdata <= ApbDataWidth'(kind);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ctrl_kind = kind;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[KindWidth-1:0] !== kind)
            note_failure($sformatf("kind register read back: expected %0d, got %0d",
                                   kind, prdata[KindWidth-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_boot_overlay();
        set_kind(KIND_NONE);
        send_word(ACC_READ, 16'h0000, 8'h00);
        send_word(ACC_READ, 16'h00FF, 8'hFF);
        send_word(ACC_READ, 16'h0100, 8'h00);
        send_word(ACC_WRITE, 16'h0000, 8'h0A);
        send_word(ACC_WRITE, BOOT_OFF_ADDR, 8'h01);
        send_word(ACC_READ, 16'h0000, 8'h00);
        send_word(ACC_WRITE, BOOT_OFF_ADDR, 8'h00);
    endtask

    task automatic test_mbc1_banking();
        set_kind(KIND_MBC1);
        send_word(ACC_WRITE, 16'h2000, 8'h00);
        send_word(ACC_WRITE, 16'h3FFF, 8'h1F);
        send_word(ACC_WRITE, 16'h6000, 8'h00);
        send_word(ACC_WRITE, 16'h4000, 8'h03);
        send_word(ACC_READ, 16'h7FFF, 8'h00);
        send_word(ACC_WRITE, 16'h0000, 8'h0A);
        send_word(ACC_WRITE, 16'h6000, 8'h01);
        send_word(ACC_WRITE, 16'h5FFF, 8'h02);
        send_word(ACC_WRITE, 16'hBFFF, 8'h55);
        send_word(ACC_READ, 16'hFFFF, 8'h00);
    endtask

    task automatic test_mbc2_mbc3_rules();
        set_kind(KIND_MBC2);
        send_word(ACC_WRITE, 16'h0010, 8'h0A);
        send_word(ACC_WRITE, 16'h2000, 8'hF0);
        send_word(ACC_READ, 16'h4000, 8'h00);
        set_kind(KIND_MBC3);
        send_word(ACC_WRITE, 16'h2000, 8'h80);
        send_word(ACC_WRITE, 16'h4000, 8'h08);
        send_word(ACC_WRITE, 16'hA000, 8'h11);
        send_word(ACC_WRITE, 16'h4000, 8'h0D);
        send_word(ACC_WRITE, 16'h4000, 8'h03);
    endtask

    task automatic test_output_stall();
        set_kind(KIND_MBC1);
        hold_pending = 1'b1;
        for (int unsigned i = 0; i < 24; i++)
            send_word(ACC_READ, 16'h4000 + 16'(i * 16'h0155), 8'(i));
    endtask

    task automatic test_random_traffic(input kind_t kind, input int unsigned count);
        int unsigned pick;
        logic mode;
        logic [15:0] addr;
        logic [7:0] data;
        set_kind(kind);
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            data = 8'($urandom_range(255));
            case ($urandom_range(5))
                0: data[3:0] = RAM_ENABLE_KEY;
                1: data = 8'($urandom_range(3));
                2: data = 8'($urandom_range(CLOCK_SEL_HIGH, CLOCK_SEL_LOW));
                3: data[4:0] = 5'd0;
                default: ;
            endcase
            mode = ACC_READ;
            addr = 16'($urandom);
            if (pick < 30) begin
                mode = ACC_WRITE;
                addr[15] = 1'b0;
            end else if (pick < 50) begin
                addr[15:14] = 2'b01;
            end else if (pick < 60) begin
                addr = ($urandom_range(1) != 0) ? 16'($urandom_range(255)) : {2'b00, addr[13:0]};
            end else if (pick < 75) begin
                mode = 1'($urandom_range(1));
                addr[15:13] = 3'b101;
            end else if (pick < 80) begin
                mode = ACC_WRITE;
                addr = BOOT_OFF_ADDR;
                if ($urandom_range(1) != 0)
                    data = 8'd1;
            end else begin
                mode = 1'($urandom_range(1));
            end
            send_word(mode, addr, data);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_pending) begin
            hold_left = LONG_HOLD;
            hold_pending = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_maps.size() == 0) begin
                note_failure($sformatf("unexpected result: target %0d, address %06h",
                                       m_target, m_mapped_address));
            end else begin
                want = expected_maps.pop_front();
                if (m_target !== want.target)
                    note_failure($sformatf("target mismatch: expected %0d, got %0d",
                                           want.target, m_target));
                if (m_mapped_address !== want.mapped_address)
                    note_failure($sformatf("mapped address mismatch: expected %06h, got %06h",
                                           want.mapped_address, m_mapped_address));
                if (m_ram_write_ok !== want.ram_write_ok)
                    note_failure($sformatf("RAM write permit mismatch: expected %0b, got %0b",
                                           want.ram_write_ok, m_ram_write_ok));
            end
            if (m_target <= TGT_OTHER)
                target_hits[m_target]++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", stall_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_mode = ACC_READ;
        s_bus_address = '0;
        s_write_data = '0;
        m_ready = 1'b0;
        hold_pending = 1'b0;
        hold_left = 0;
        stall_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        words_sent = 0;
        results_seen = 0;
        target_hits = '{default: 0};
        ctrl_kind = KIND_NONE;
        rom_bank_sel = 7'd1;
        ram_bank_sel = '0;
        cart_ram_open = 1'b0;
        mbc1_ram_mode = 1'b1;
        ram_over_clock = 1'b1;
        boot_rom_mapped = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_boot_overlay();
        test_mbc1_banking();
        test_mbc2_mbc3_rules();
        test_output_stall();
        for (int unsigned p = 0; p < 4; p++) begin
            send_idle_pct = send_mix[p];
            recv_stall_pct = recv_mix[p];
            for (int unsigned k = 0; k < 4; k++)
                test_random_traffic(kind_order[(k + p) % 4], WORDS_PER_KIND);
        end
        recv_stall_pct = 0;
        wait_for_results();
        repeat (4) @(posedge aclk);

        $display("Sent %0d words, checked %0d results (boot %0d, ROM %0d, RAM %0d, %s",
                 words_sent, results_seen, target_hits[TGT_BOOT], target_hits[TGT_ROM],
                 target_hits[TGT_RAM],
                 $sformatf("bank %0d, other %0d).",
                           target_hits[TGT_BANKREG], target_hits[TGT_OTHER]));
        $display("%s plus a %0d-cycle output hold; %0d failures.",
                 "All controller kinds ran under four handshake mixes",
                 LONG_HOLD, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
